FILE: design/swrp_pkg.sv
// Shared types and constants for the set with random pick.
`timescale 1ns / 1ps

package swrp_pkg;

	// Store size and derived widths
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths
	localparam int OP_W    = 2;
	localparam int VAL_W   = 32;
	localparam int DRAW_W  = 16;
	localparam int ST_W    = 3;
	localparam int TOTAL_W = 7;
	localparam int STEP_W  = $clog2(DRAW_W);

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

	// Status codes
	localparam logic [ST_W-1:0] ST_DONE    = 3'd0;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd1;
	localparam logic [ST_W-1:0] ST_ABSENT  = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;

	// Values broadcast to every cell during a sweep
	typedef struct packed {
		logic [VAL_W-1:0] key;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] sel;
	} bcast_t;

	// Write port broadcast to every cell
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] data;
	} wr_t;

	// Search wave handed from cell to cell
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] pos;
		logic [VAL_W-1:0] data;
	} wave_t;

endpackage

FILE: design/swrp_cell.sv
// One storage cell of the chain: holds an entry, matches the key, taps the selected entry.
`timescale 1ns / 1ps

module swrp_cell
	import swrp_pkg::*;
(
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  bcast_t           bc,
	input  wr_t              wr,
	input  wave_t            wave_in,
	output wave_t            wave_out
);

	logic [VAL_W-1:0] entry_q;
	wave_t            wave_q;
	logic             valid;

	// Store a new entry when addressed
	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == idx) begin
			entry_q <= wr.data;
		end
	end

	assign valid = ({1'b0, idx} < bc.count);

	// Advance the wave by one cell, adding a hit or the selected entry
	always_ff @(posedge clk) begin
		if (valid && entry_q == bc.key) begin
			wave_q.found <= 1'b1;
			wave_q.pos   <= idx;
		end else begin
			wave_q.found <= wave_in.found;
			wave_q.pos   <= wave_in.pos;
		end
		wave_q.data <= (idx == bc.sel) ? entry_q : wave_in.data;
	end

	assign wave_out = wave_q;

endmodule

FILE: design/swrp_mod.sv
// Restoring modulo unit: reduces the random draw by the entry count, one bit a cycle.
`timescale 1ns / 1ps

module swrp_mod
	import swrp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DRAW_W-1:0] draw,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [IDX_W-1:0]  rem
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DRAW_W-1:0] num_q;
	logic [CNT_W-1:0]  div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W-1:0]  rem_next;

	// Shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, num_q[DRAW_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = CNT_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = CNT_W'(trial);
		end
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DRAW_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= draw;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DRAW_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = IDX_W'(rem_q);

endmodule

FILE: design/set_with_random_pick.sv
// Top level of the set with random pick: control, cell chain and result register.
//
// Keeps up to CAPACITY distinct 32-bit values with a count. Requests arrive on
// the s_ stream (op in s_tuser: insert, remove or random pick); one result per
// request leaves on the m_ stream. An insert of a present value or into a full
// store is refused, a remove of an absent value is refused, a pick from an empty
// set reports empty.
// Inserts, removes and picks from a non-empty set sweep a row of CAPACITY
// cells, one cell per cycle; the sweep finds the matching entry and taps the
// selected entry. A pick first runs the bit-serial modulo of the draw by the
// count ahead of the sweep; other requests go straight to the result.
// One request is in work at a time; s_tready returns with the registered result,
// even if that result is still waiting on m_tready.
// If the receiver stalls, the finished result holds and the next request waits
// in its last step until the output register frees.
// Reset empties the set; stored values are not cleared and never read unwritten.
`timescale 1ns / 1ps

module set_with_random_pick
	import swrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // item_value[31:0], random_draw[47:32]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // picked_value[31:0], entry_total[38:32], zero[39]
	output logic [3:0]  m_tuser   // ok[0], status[3:1]
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_SWEEP,
		S_FINISH
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    sweep_q;
	logic                mod_start_q;
	logic                m_tvalid_q;
	logic                ok_q;
	logic [ST_W-1:0]     status_q;
	logic [VAL_W-1:0]    picked_q;
	logic [TOTAL_W-1:0]  total_q;

	logic [OP_W-1:0]     op_q;
	logic [VAL_W-1:0]    key_q;
	logic [DRAW_W-1:0]   draw_q;
	logic [IDX_W-1:0]    sel_q;

	logic                accept;
	logic                out_free;
	logic                mod_done;
	logic [IDX_W-1:0]    mod_rem;
	bcast_t              bc;
	wr_t                 wr;
	wave_t               wave [CAPACITY+1];
	wave_t               tail;

	logic                res_ok;
	logic [ST_W-1:0]     res_status;
	logic [VAL_W-1:0]    res_picked;
	logic [CNT_W-1:0]    res_count;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// Modulo of the draw by the count
	swrp_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start_q),
		.draw    (draw_q),
		.divisor (count_q),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// Cell chain
	assign bc.key   = key_q;
	assign bc.count = count_q;
	assign bc.sel   = sel_q;
	assign wave[0]  = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		swrp_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(i)),
			.bc       (bc),
			.wr       (wr),
			.wave_in  (wave[i]),
			.wave_out (wave[i+1])
		);
	end

	assign tail = wave[CAPACITY];

	// Decide the result and the store update at the end of the sweep
	always_comb begin
		res_ok     = 1'b0;
		res_status = ST_DONE;
		res_picked = '0;
		res_count  = count_q;
		wr.en      = 1'b0;
		wr.idx     = tail.pos;
		wr.data    = tail.data;
		case (op_q)
			OP_INSERT: begin
				wr.idx  = IDX_W'(count_q);
				wr.data = key_q;
				if (tail.found) begin
					res_status = ST_PRESENT;
				end else if (count_q >= CNT_W'(CAPACITY)) begin
					res_status = ST_FULL;
				end else begin
					res_ok    = 1'b1;
					res_count = count_q + 1'b1;
					wr.en     = (state_q == S_FINISH) && out_free;
				end
			end
			OP_REMOVE: begin
				if (!tail.found) begin
					res_status = ST_ABSENT;
				end else begin
					res_ok    = 1'b1;
					res_count = count_q - 1'b1;
					wr.en     = (state_q == S_FINISH) && out_free;
				end
			end
			OP_PICK: begin
				if (count_q == '0) begin
					res_status = ST_EMPTY;
				end else begin
					res_ok     = 1'b1;
					res_picked = tail.data;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequence requests, hold the count and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sweep_q     <= '0;
			mod_start_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			ok_q        <= 1'b0;
			status_q    <= ST_DONE;
			picked_q    <= '0;
			total_q     <= '0;
		end else begin
			mod_start_q <= (state_q == S_IDLE) && accept && (s_tuser == OP_PICK)
				&& (count_q != '0);
			// Raise the result when the last step finishes, drop it once taken
			if (state_q == S_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					sweep_q <= '0;
					if (accept) begin
						if (s_tuser == OP_INSERT || s_tuser == OP_REMOVE) begin
							state_q <= S_SWEEP;
						end else if (s_tuser == OP_PICK && count_q != '0) begin
							state_q <= S_MOD;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						ok_q       <= res_ok;
						status_q   <= res_status;
						picked_q   <= res_picked;
						total_q    <= TOTAL_W'(res_count);
						count_q    <= res_count;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request and the tap index
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			key_q  <= s_tdata[VAL_W-1:0];
			draw_q <= s_tdata[VAL_W+DRAW_W-1:VAL_W];
			sel_q  <= IDX_W'(count_q - 1'b1);
		end else if (state_q == S_MOD && mod_done) begin
			sel_q <= mod_rem;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, total_q, picked_q};
	assign m_tuser  = {status_q, ok_q};

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while another is in work");

	a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == S_MOD)
		else $error("modulo result outside the modulo step");

	a_write_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> m_tvalid_q && state_q == S_IDLE)
		else $error("store write without a registered result");
`endif

endmodule

FILE: tb/sv/tb_set_with_random_pick.sv
// Self-checking testbench for the set with random pick: stream driver, monitor and set predictor.
`timescale 1ns / 1ps

module tb_set_with_random_pick;
	import swrp_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1430;
	localparam int QUIET_LIMIT  = 4000;
	localparam int LONG_HOLD    = 600;
	localparam int HOLD_AT      = 250;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [VAL_W-1:0]  value;
		logic [DRAW_W-1:0] draw;
		logic              sync;  // wait until every outcome is back before offering
	} set_req_t;

	typedef struct {
		logic               ok;
		logic [ST_W-1:0]    status;
		logic [VAL_W-1:0]   picked;
		logic [TOTAL_W-1:0] total;
	} set_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // item_value[31:0], random_draw[47:32]
	logic [1:0]  s_tuser = '0;   // op[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // picked_value[31:0], entry_total[38:32], zero[39]
	logic [3:0]  m_tuser;        // ok[0], status[3:1]

	set_req_t    request_q[$];
	set_result_t outcome_q[$];

	// Predictor copy of the set
	logic [VAL_W-1:0] set_vals[CAPACITY];
	int set_count = 0;

	int total_items = 0;
	int sent_count = 0;
	int result_count = 0;
	int errors = 0;
	int op_seen[4] = '{0, 0, 0, 0};
	int status_seen[8] = '{0, 0, 0, 0, 0, 0, 0, 0};

	set_with_random_pick dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial forever #5 clk = ~clk;

	// Apply one accepted request to the predicted set and queue its outcome
	task automatic apply_set_op(input set_req_t req);
		set_result_t res;
		int pos;
		pos = -1;
		res.ok = 1'b0;
		res.status = ST_DONE;
		res.picked = '0;
		for (int i = 0; i < set_count; i++)
			if (pos < 0 && set_vals[i] == req.value)
				pos = i;
		case (req.op)
			OP_INSERT: begin
				if (pos >= 0) begin
					res.status = ST_PRESENT;
				end else if (set_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					set_vals[set_count] = req.value;
					set_count++;
					res.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos < 0) begin
					res.status = ST_ABSENT;
				end else begin
					// fill the hole with the last entry
					set_vals[pos] = set_vals[set_count - 1];
					set_count--;
					res.ok = 1'b1;
				end
			end
			OP_PICK: begin
				if (set_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.picked = set_vals[int'(req.draw) % set_count];
					res.ok = 1'b1;
				end
			end
			default: begin
				// unused code leaves the set alone
			end
		endcase
		res.total = TOTAL_W'(set_count);
		op_seen[req.op]++;
		status_seen[res.status]++;
		outcome_q = {outcome_q, res};
	endtask

	// Drive requests in bursts with random gaps
	always @(posedge clk or negedge arst_n) begin : drive
		set_req_t cur_req;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_set_op(cur_req);
				sent_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (request_q.size() == 0
						|| (request_q[0].sync && outcome_q.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else begin
					cur_req = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_req.draw, cur_req.value};
					s_tuser <= cur_req.op;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 25);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Check results and pattern the receiver stalls
	always @(posedge clk or negedge arst_n) begin : watch
		set_result_t got;
		set_result_t want;
		int hold_left;
		int mode;
		int mode_left;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			mode = 0;
			mode_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.picked = m_tdata[31:0];
				got.total = m_tdata[38:32];
				got.ok = m_tuser[0];
				got.status = m_tuser[3:1];
				result_count++;
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got ok %0d status %0d value %h",
						$time, got.ok, got.status, got.picked);
					errors++;
				end else begin
					want = outcome_q.pop_front();
					if (got.ok !== want.ok) begin
						$display("%0t: ok mismatch: expected %0d, got %0d", $time, want.ok, got.ok);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, got.status);
						errors++;
					end
					if (got.picked !== want.picked) begin
						$display("%0t: picked value mismatch: expected %h, got %h",
							$time, want.picked, got.picked);
						errors++;
					end
					if (got.total !== want.total) begin
						$display("%0t: entry total mismatch: expected %0d, got %0d",
							$time, want.total, got.total);
						errors++;
					end
				end
				if (result_count == HOLD_AT)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(2);
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(1) == 1);
					default: m_tready <= ($urandom_range(3) == 0);
				endcase
			end
		end
	end

	// End the run if no item moves for too long
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout with %0d outcomes outstanding", $time, outcome_q.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic add_req(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
			input logic [DRAW_W-1:0] draw, input logic sync);
		set_req_t req;
		req.op = op;
		req.value = value;
		req.draw = draw;
		req.sync = sync;
		request_q = {request_q, req};
		total_items++;
	endtask

	function automatic bit live_has(ref logic [VAL_W-1:0] live[$], input logic [VAL_W-1:0] v);
		foreach (live[i])
			if (live[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// Build the stimulus, release reset and wait for the run to drain
	initial begin : stimulus
		logic [VAL_W-1:0] live_vals[$];
		logic [VAL_W-1:0] v;
		logic [OP_W-1:0] op;
		int n;
		int kind;
		int plen;
		int r;
		int k;

		// Directed: empty set, extremes, duplicates, last-entry and first-entry removal
		add_req(OP_PICK,   32'h0000_0000, 16'hFFFF, 1'b0);
		add_req(OP_REMOVE, 32'h0000_0005, 16'h0000, 1'b0);
		add_req(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		add_req(OP_INSERT, 32'h8000_0000, 16'h0000, 1'b0);
		add_req(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
		add_req(OP_INSERT, 32'h0000_0000, 16'h0000, 1'b0);
		add_req(OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		add_req(OP_INSERT, 32'h8000_0000, 16'h0000, 1'b0);
		add_req(OP_PICK,   32'hFFFF_FFFF, 16'h0000, 1'b0);
		add_req(OP_PICK,   32'h0000_0000, 16'hFFFF, 1'b0);
		add_req(OP_PICK,   32'h1234_5678, 16'h0003, 1'b0);
		add_req(OP_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		add_req(OP_REMOVE, 32'h8000_0000, 16'h0000, 1'b0);
		add_req(OP_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		add_req(OP_UNUSED, 32'h0000_0000, 16'h0000, 1'b0);
		add_req(OP_INSERT, 32'h5555_5555, 16'h5555, 1'b0);
		add_req(OP_INSERT, 32'hAAAA_AAAA, 16'hAAAA, 1'b0);
		add_req(OP_PICK,   32'h0000_0000, 16'h5555, 1'b0);
		add_req(OP_PICK,   32'h0000_0000, 16'hAAAA, 1'b0);
		live_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};

		// Random phases: fill to full first, then drain to empty, then a mix
		n = 0;
		kind = 0;
		while (n < RANDOM_ITEMS) begin
			plen = (kind < 2) ? 140 : $urandom_range(30, 120);
			for (int j = 0; j < plen && n < RANDOM_ITEMS; j++) begin
				r = $urandom_range(99);
				case (kind == 0 ? 0 : kind == 1 ? 1 : (kind % 3))
					0: op = (r < 80) ? OP_INSERT : (r < 90) ? OP_PICK
						: (r < 97) ? OP_REMOVE : OP_UNUSED;
					1: op = (r < 75) ? OP_REMOVE : (r < 90) ? OP_PICK
						: (r < 97) ? OP_INSERT : OP_UNUSED;
					default: op = (r < 32) ? OP_INSERT : (r < 64) ? OP_REMOVE
						: (r < 94) ? OP_PICK : OP_UNUSED;
				endcase
				v = $urandom;
				if (op == OP_INSERT) begin
					if (live_vals.size() != 0 && $urandom_range(4) == 0)
						v = live_vals[$urandom_range(live_vals.size() - 1)];
					if (!live_has(live_vals, v) && live_vals.size() < CAPACITY)
						live_vals = {live_vals, v};
				end else if (op == OP_REMOVE && live_vals.size() != 0
						&& $urandom_range(6) != 0) begin
					k = $urandom_range(live_vals.size() - 1);
					v = live_vals[k];
					live_vals.delete(k);
				end
				add_req(op, v, ($urandom_range(3) == 0) ? DRAW_W'($urandom_range(70))
					: DRAW_W'($urandom_range(65535)), (n == 0 || n == RANDOM_ITEMS / 2));
				n++;
			end
			kind = (kind < 2) ? kind + 1 : $urandom_range(2, 4);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_count != total_items)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);

		$display("Covered %0d requests: %0d insert, %0d remove, %0d pick, %0d unused code.",
			total_items, op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_PICK],
			op_seen[OP_UNUSED]);
		$display("Outcomes: %0d done, %0d present, %0d absent, %0d full, %0d empty.",
			status_seen[ST_DONE], status_seen[ST_PRESENT], status_seen[ST_ABSENT],
			status_seen[ST_FULL], status_seen[ST_EMPTY]);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
